// ===== rtl/arp_udp_frame_generator_macros.svh =====
// assertion macros for the arp/udp frame generator checker
`ifndef ARP_UDP_FRAME_GENERATOR_MACROS_SVH
`define ARP_UDP_FRAME_GENERATOR_MACROS_SVH

// condition now implies consequence in the same cycle
`define AUFG_ASSERT_NOW(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// condition now implies consequence in the next cycle
`define AUFG_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/aufg_pkg.sv =====
// shared types, constants and helpers for the arp/udp frame generator
`timescale 1ns / 1ps

package aufg_pkg;

   localparam int PAYLOAD_LEN_DEFAULT = 15;
   localparam int HDR_LEN             = 42;
   localparam int MSG_LEN             = 15;
   localparam int CSUM_POS            = 24;
   localparam int CSUM_LAT            = 5;
   localparam int PATCH_CELL          = CSUM_POS - CSUM_LAT;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 48;

   localparam logic [7:0] MESSAGE [MSG_LEN] = '{
      8'h48, 8'h65, 8'h6C, 8'h6C, 8'h6F, 8'h20, 8'h4E, 8'h65,
      8'h74, 8'h77, 8'h6F, 8'h72, 8'h6B, 8'h21, 8'h00
   };

   localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_VER_IHL    = 8'h45;
   localparam logic [7:0]  IP_FLAGS_DF   = 8'h40;
   localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_MAC   = 3'd0,
      CSR_SOURCE_IP    = 3'd1,
      CSR_UDP_DEST_MAC = 3'd2,
      CSR_SOURCE_PORT  = 3'd3,
      CSR_DEST_PORT    = 3'd4,
      CSR_IP_IDENT     = 3'd5,
      CSR_TIME_TO_LIVE = 3'd6
   } aufg_csr_type;

   typedef struct packed {
      logic        req_type;
      logic [31:0] target_ip;
   } aufg_req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } aufg_rsp_type;

   typedef struct packed {
      logic [47:0] source_mac;
      logic [31:0] source_ip;
      logic [47:0] udp_dest_mac;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] ip_ident;
      logic [7:0]  time_to_live;
   } aufg_cfg_type;

   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] data;
   } aufg_cell_type;

   function automatic logic [7:0] payload_byte(input int idx);
      logic [7:0] b;
      b = 8'h00;
      if (idx >= 0 && idx < MSG_LEN) begin
         b = MESSAGE[4'(idx)];
      end
      return b;
   endfunction

endpackage

// ===== rtl/aufg_cell.sv =====
// one byte cell of the frame shift chain
`timescale 1ns / 1ps

module aufg_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  aufg_pkg::aufg_cell_type load_cell,
   input  logic                    patch,
   input  logic [7:0]              patch_data,
   input  aufg_pkg::aufg_cell_type shift_in,
   output aufg_pkg::aufg_cell_type cell_ff
);

   aufg_pkg::aufg_cell_type cell_in;

   always_comb begin
      cell_in = shift_in;
      if (load) begin
         cell_in = load_cell;
      end else if (patch) begin
         cell_in.data = patch_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

endmodule

// ===== rtl/aufg_image.sv =====
// frame image builder: header and payload bytes for the chain load
`timescale 1ns / 1ps

module aufg_image #(
   parameter int PAYLOAD_LEN = aufg_pkg::PAYLOAD_LEN_DEFAULT
) (
   input  aufg_pkg::aufg_cfg_type  cfg,
   input  aufg_pkg::aufg_req_type  req,
   output aufg_pkg::aufg_cell_type image [aufg_pkg::HDR_LEN + PAYLOAD_LEN]
);

   localparam int FRAME_CELLS = aufg_pkg::HDR_LEN + PAYLOAD_LEN;
   localparam int HDR_BITS    = aufg_pkg::HDR_LEN * 8;
   localparam logic [15:0] UDP_LEN = 16'(8 + PAYLOAD_LEN);
   localparam logic [15:0] IP_LEN  = 16'(28 + PAYLOAD_LEN);

   logic [HDR_BITS-1:0] arp_hdr;
   logic [HDR_BITS-1:0] udp_hdr;
   logic [HDR_BITS-1:0] hdr;

   assign arp_hdr = {48'hFFFF_FFFF_FFFF, cfg.source_mac, aufg_pkg::ETH_TYPE_ARP,
                     16'h0001, aufg_pkg::ETH_TYPE_IPV4, 8'd6, 8'd4, 16'h0001,
                     cfg.source_mac, cfg.source_ip, 48'h0, req.target_ip};

   // checksum field left zero, patched in the chain later
   assign udp_hdr = {cfg.udp_dest_mac, cfg.source_mac, aufg_pkg::ETH_TYPE_IPV4,
                     aufg_pkg::IP_VER_IHL, 8'h00, IP_LEN, cfg.ip_ident,
                     aufg_pkg::IP_FLAGS_DF, 8'h00, cfg.time_to_live,
                     aufg_pkg::IP_PROTO_UDP, 16'h0000, cfg.source_ip, req.target_ip,
                     cfg.source_port, cfg.dest_port, UDP_LEN, 16'h0000};

   assign hdr = req.req_type ? udp_hdr : arp_hdr;

   always_comb begin
      for (int i = 0; i < FRAME_CELLS; i++) begin
         if (i < aufg_pkg::HDR_LEN) begin
            image[i].data  = hdr[(aufg_pkg::HDR_LEN - 1 - i) * 8 +: 8];
            image[i].valid = 1'b1;
         end else begin
            image[i].data  = aufg_pkg::payload_byte(i - aufg_pkg::HDR_LEN);
            image[i].valid = req.req_type;
         end
         image[i].last = req.req_type ? (i == FRAME_CELLS - 1)
                                      : (i == aufg_pkg::HDR_LEN - 1);
      end
   end

endmodule

// ===== rtl/aufg_csum.sv =====
// pipelined ipv4 header checksum with full carry fold
`timescale 1ns / 1ps

module aufg_csum #(
   parameter int PAYLOAD_LEN = aufg_pkg::PAYLOAD_LEN_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  aufg_pkg::aufg_cfg_type cfg,
   input  logic [31:0]            target_ip,
   output logic                   patch,
   output logic [15:0]            csum_ff
);

   // version/ihl, flags and total length words
   localparam logic [15:0] CSUM_BASE =
      16'({aufg_pkg::IP_VER_IHL, 8'h00} + {aufg_pkg::IP_FLAGS_DF, 8'h00} + 28 + PAYLOAD_LEN);

   logic [aufg_pkg::CSUM_LAT-1:0] v_ff;
   logic [aufg_pkg::CSUM_LAT-1:0] v_in;
   logic [16:0] a0_ff, a1_ff, a2_ff, a3_ff;
   logic [17:0] b0_ff, b1_ff;
   logic [18:0] c_ff;
   logic [16:0] f_ff;
   logic [15:0] fold;

   assign v_in = {v_ff[aufg_pkg::CSUM_LAT-2:0], start};
   assign fold = f_ff[15:0] + {15'h0, f_ff[16]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      a0_ff   <= {1'b0, CSUM_BASE} + {1'b0, cfg.ip_ident};
      a1_ff   <= {1'b0, cfg.time_to_live, aufg_pkg::IP_PROTO_UDP} + {1'b0, cfg.source_ip[31:16]};
      a2_ff   <= {1'b0, cfg.source_ip[15:0]} + {1'b0, target_ip[31:16]};
      a3_ff   <= {1'b0, target_ip[15:0]};
      b0_ff   <= {1'b0, a0_ff} + {1'b0, a1_ff};
      b1_ff   <= {1'b0, a2_ff} + {1'b0, a3_ff};
      c_ff    <= {1'b0, b0_ff} + {1'b0, b1_ff};
      f_ff    <= {1'b0, c_ff[15:0]} + {14'h0, c_ff[18:16]};
      csum_ff <= ~fold;
   end

   assign patch = v_ff[aufg_pkg::CSUM_LAT-1];

endmodule

// ===== rtl/arp_udp_frame_generator.sv =====
// top level: arp request and ipv4/udp frame generator
//
//   channel  ports                          handshake
//   request  start, busy, req_data          taken when start && !busy
//   result   rsp_strobe, rsp_data           one byte per cycle, no stall
//   config   csr_we, csr_index, csr_wdata   write when csr_we
//
// a frame loads whole into a chain of byte cells and shifts out one byte a cycle;
// a frame is 42 bytes for arp, 42 + PAYLOAD_LEN for udp. the first byte shows the cycle
// after the request is taken. busy drops during the last byte, so frames run
// back to back with no gap. the ip checksum is patched into the chain from its pipeline
// before those bytes shift out. reset is synchronous and clears the chain and the checksum valid bits.
`timescale 1ns / 1ps

module arp_udp_frame_generator #(
   parameter int PAYLOAD_LEN = aufg_pkg::PAYLOAD_LEN_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  aufg_pkg::aufg_req_type              req_data,
   output logic                                rsp_strobe,
   output aufg_pkg::aufg_rsp_type              rsp_data,
   input  logic                                csr_we,
   input  logic [aufg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [aufg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FRAME_CELLS = aufg_pkg::HDR_LEN + PAYLOAD_LEN;

   aufg_pkg::aufg_cfg_type  cfg_ff;
   aufg_pkg::aufg_cfg_type  cfg_in;
   aufg_pkg::aufg_cell_type image [FRAME_CELLS];
   aufg_pkg::aufg_cell_type chain [FRAME_CELLS];
   logic                    accept;
   logic                    csum_patch;
   logic [15:0]             csum;

   assign accept = start && !busy;
   assign busy   = chain[1].valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (aufg_pkg::aufg_csr_type'(csr_index))
            aufg_pkg::CSR_SOURCE_MAC:   cfg_in.source_mac   = csr_wdata;
            aufg_pkg::CSR_SOURCE_IP:    cfg_in.source_ip    = csr_wdata[31:0];
            aufg_pkg::CSR_UDP_DEST_MAC: cfg_in.udp_dest_mac = csr_wdata;
            aufg_pkg::CSR_SOURCE_PORT:  cfg_in.source_port  = csr_wdata[15:0];
            aufg_pkg::CSR_DEST_PORT:    cfg_in.dest_port    = csr_wdata[15:0];
            aufg_pkg::CSR_IP_IDENT:     cfg_in.ip_ident     = csr_wdata[15:0];
            aufg_pkg::CSR_TIME_TO_LIVE: cfg_in.time_to_live = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_mac   <= 48'h0;
         cfg_ff.source_ip    <= 32'h7F00_0001;
         cfg_ff.udp_dest_mac <= 48'h0;
         cfg_ff.source_port  <= 16'd43966;
         cfg_ff.dest_port    <= 16'd8080;
         cfg_ff.ip_ident     <= 16'h8397;
         cfg_ff.time_to_live <= 8'h40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   aufg_image #(
      .PAYLOAD_LEN(PAYLOAD_LEN)
   ) u_image (
      .cfg   (cfg_ff),
      .req   (req_data),
      .image (image)
   );

   aufg_csum #(
      .PAYLOAD_LEN(PAYLOAD_LEN)
   ) u_csum (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && req_data.req_type),
      .cfg       (cfg_ff),
      .target_ip (req_data.target_ip),
      .patch     (csum_patch),
      .csum_ff   (csum)
   );

   for (genvar i = 0; i < FRAME_CELLS; i++) begin : g_cell
      aufg_pkg::aufg_cell_type shift_in;
      logic                    patch;
      logic [7:0]              patch_data;

      if (i == FRAME_CELLS - 1) begin : g_tail
         assign shift_in = '0;
      end else begin : g_link
         assign shift_in = chain[i+1];
      end

      if (i == aufg_pkg::PATCH_CELL) begin : g_csum_hi
         assign patch      = csum_patch;
         assign patch_data = csum[15:8];
      end else if (i == aufg_pkg::PATCH_CELL + 1) begin : g_csum_lo
         assign patch      = csum_patch;
         assign patch_data = csum[7:0];
      end else begin : g_plain
         assign patch      = 1'b0;
         assign patch_data = 8'h00;
      end

      aufg_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (accept),
         .load_cell  (image[i]),
         .patch      (patch),
         .patch_data (patch_data),
         .shift_in   (shift_in),
         .cell_ff    (chain[i])
      );
   end

   assign rsp_strobe          = chain[0].valid;
   assign rsp_data.frame_byte = chain[0].data;
   assign rsp_data.last_byte  = chain[0].last;

endmodule

// ===== rtl/aufg_checker.sv =====
// port-level checker for the frame generator, bound to the top level
`timescale 1ns / 1ps
`include "arp_udp_frame_generator_macros.svh"

module aufg_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input aufg_pkg::aufg_rsp_type rsp_data
);

   logic accept;

   assign accept = start && !busy;

   `AUFG_ASSERT_NEXT(a_first_byte, accept, rsp_strobe, "no byte after an accepted item")
   `AUFG_ASSERT_NOW(a_busy_mid_frame, busy, rsp_strobe && !rsp_data.last_byte, "busy outside a frame")
   `AUFG_ASSERT_NEXT(a_frame_runs, rsp_strobe && !rsp_data.last_byte, rsp_strobe, "gap inside a frame")
   `AUFG_ASSERT_NEXT(a_frame_ends, rsp_strobe && rsp_data.last_byte && !accept, !rsp_strobe, "byte after last with no item")

endmodule

bind arp_udp_frame_generator aufg_checker u_checker (.*);

// ===== sim/tb_arp_udp_frame_generator.sv =====
// self-checking testbench for the arp request / ipv4 udp frame generator
`timescale 1ns / 1ps

module tb_arp_udp_frame_generator;

   localparam int FRAME_PAYLOAD = aufg_pkg::PAYLOAD_LEN_DEFAULT;
   localparam int FRAME_MAX     = aufg_pkg::HDR_LEN + FRAME_PAYLOAD;
   localparam int IDX_W         = aufg_pkg::CSR_INDEX_W;
   localparam int CSR_W         = aufg_pkg::CSR_DATA_W;

   localparam logic FRAME_ARP = 1'b0;
   localparam logic FRAME_UDP = 1'b1;

   localparam logic [IDX_W-1:0] CSR_UNUSED = 3'd7;

   localparam logic [8*14-1:0] GREETING = "Hello Network!";

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [IDX_W-1:0]       idx;
      logic [CSR_W-1:0]       wdata;
      aufg_pkg::aufg_req_type req;
      logic                   has_csum;
      logic [15:0]            csum;
   } dir_row_type;

   localparam int DIR_ROWS = 26;

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_ARP, 32'h0000_0000}, 1'b0, 16'h0},
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_UDP, 32'h0000_0000}, 1'b1, 16'h382a},
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_ARP, 32'hffff_ffff}, 1'b0, 16'h0},
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_UDP, 32'hffff_ffff}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_SOURCE_MAC, 48'hffff_ffff_ffff, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_SOURCE_IP, 48'hffff_ffff_ffff, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_UDP_DEST_MAC, 48'hffff_ffff_ffff, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_SOURCE_PORT, 48'hffff_ffff_ffff, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_DEST_PORT, 48'hffff_ffff_ffff, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_IP_IDENT, 48'hffff_ffff_ffff, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_TIME_TO_LIVE, 48'hffff_ffff_ffff, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_ARP, 32'hffff_ffff}, 1'b0, 16'h0},
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_UDP, 32'hffff_ffff}, 1'b1, 16'h7bc2},
      // unknown index must leave every register alone
      '{ROW_CFG, CSR_UNUSED, 48'h0, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_UDP, 32'hffff_ffff}, 1'b1, 16'h7bc2},
      // over-wide data, only the low byte lands
      '{ROW_CFG, aufg_pkg::CSR_TIME_TO_LIVE, 48'habcd_ef12_3400, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      // checksum carry needs a second fold
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_UDP, 32'h7ac6_0000}, 1'b1, 16'hfffc},
      '{ROW_CFG, aufg_pkg::CSR_SOURCE_MAC, 48'h0123_4567_89ab, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_UDP_DEST_MAC, 48'ha1b2_c3d4_e5f6, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_SOURCE_PORT, 48'h0, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_DEST_PORT, 48'h0, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_SOURCE_IP, 48'h0, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_CFG, aufg_pkg::CSR_IP_IDENT, 48'h0, {FRAME_ARP, 32'h0}, 1'b0, 16'h0},
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_UDP, 32'h0000_0000}, 1'b0, 16'h0},
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_ARP, 32'h1234_5678}, 1'b0, 16'h0},
      '{ROW_REQ, aufg_pkg::CSR_SOURCE_MAC, 48'h0, {FRAME_UDP, 32'hc0a8_0101}, 1'b0, 16'h0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   aufg_pkg::aufg_req_type req_data = '0;
   logic                   rsp_strobe;
   aufg_pkg::aufg_rsp_type rsp_data;
   logic                   csr_we = 1'b0;
   logic [IDX_W-1:0]       csr_index = '0;
   logic [CSR_W-1:0]       csr_wdata = '0;

   aufg_pkg::aufg_cfg_type cfg_shadow;
   aufg_pkg::aufg_rsp_type frame_q [$];

   bit idling;
   int fail_count;
   int arp_frames;
   int udp_frames;
   int bytes_checked;
   int csr_writes;

   arp_udp_frame_generator #(
      .PAYLOAD_LEN(FRAME_PAYLOAD)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic build_frame(input aufg_pkg::aufg_req_type req, input logic has_csum,
                              input logic [15:0] typed_csum);
      logic [7:0]  fr [FRAME_MAX];
      logic [31:0] sum;
      logic [15:0] csum;
      logic [15:0] word;
      int          len;
      int          i;
      for (i = 0; i < FRAME_MAX; i++) begin
         fr[i] = 8'h00;
      end
      if (req.req_type == FRAME_ARP) begin
         len = aufg_pkg::HDR_LEN;
         for (i = 0; i < 6; i++) begin
            fr[i]      = 8'hff;
            fr[6 + i]  = cfg_shadow.source_mac[8*(5-i) +: 8];
            fr[22 + i] = cfg_shadow.source_mac[8*(5-i) +: 8];
         end
         {fr[12], fr[13]} = aufg_pkg::ETH_TYPE_ARP;
         {fr[14], fr[15]} = 16'h0001;
         {fr[16], fr[17]} = aufg_pkg::ETH_TYPE_IPV4;
         fr[18] = 8'd6;
         fr[19] = 8'd4;
         {fr[20], fr[21]} = 16'h0001;
         {fr[28], fr[29], fr[30], fr[31]} = cfg_shadow.source_ip;
         {fr[38], fr[39], fr[40], fr[41]} = req.target_ip;
         arp_frames++;
      end else begin
         len = FRAME_MAX;
         for (i = 0; i < 6; i++) begin
            fr[i]     = cfg_shadow.udp_dest_mac[8*(5-i) +: 8];
            fr[6 + i] = cfg_shadow.source_mac[8*(5-i) +: 8];
         end
         {fr[12], fr[13]} = aufg_pkg::ETH_TYPE_IPV4;
         fr[14] = aufg_pkg::IP_VER_IHL;
         {fr[16], fr[17]} = 16'(28 + FRAME_PAYLOAD);
         {fr[18], fr[19]} = cfg_shadow.ip_ident;
         fr[20] = aufg_pkg::IP_FLAGS_DF;
         fr[22] = cfg_shadow.time_to_live;
         fr[23] = aufg_pkg::IP_PROTO_UDP;
         {fr[26], fr[27], fr[28], fr[29]} = cfg_shadow.source_ip;
         {fr[30], fr[31], fr[32], fr[33]} = req.target_ip;
         sum = '0;
         for (i = 0; i < 10; i++) begin
            word = {fr[14 + 2*i], fr[15 + 2*i]};
            sum  = sum + {16'h0, word};
         end
         while (sum > 32'h0000_ffff) begin
            sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
         end
         csum = ~sum[15:0];
         if (has_csum) begin
            csum = typed_csum;
         end
         {fr[24], fr[25]} = csum;
         {fr[34], fr[35]} = cfg_shadow.source_port;
         {fr[36], fr[37]} = cfg_shadow.dest_port;
         {fr[38], fr[39]} = 16'(8 + FRAME_PAYLOAD);
         for (i = 0; i < FRAME_PAYLOAD; i++) begin
            fr[42 + i] = (i < 14) ? GREETING[8*(13-i) +: 8] : 8'h00;
         end
         udp_frames++;
      end
      for (i = 0; i < len; i++) begin
         frame_q.push_back('{frame_byte: fr[i], last_byte: (i == len - 1)});
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idling || r < 60) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 80);
   endfunction

   task automatic send_req(input aufg_pkg::aufg_req_type req, input logic has_csum,
                           input logic [15:0] typed_csum);
      int gap;
      start    <= 1'b1;
      req_data <= req;
      do begin
         @(posedge clock);
      end while (busy);
      build_frame(req, has_csum, typed_csum);
      gap = pick_gap();
      if (gap > 0) begin
         start    <= 1'b0;
         req_data <= {1'($urandom_range(0, 1)), $urandom()};
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (frame_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= CSR_W'({$urandom(), $urandom()});
      @(posedge clock);
      case (idx)
         aufg_pkg::CSR_SOURCE_MAC:   cfg_shadow.source_mac   = value;
         aufg_pkg::CSR_SOURCE_IP:    cfg_shadow.source_ip    = value[31:0];
         aufg_pkg::CSR_UDP_DEST_MAC: cfg_shadow.udp_dest_mac = value;
         aufg_pkg::CSR_SOURCE_PORT:  cfg_shadow.source_port  = value[15:0];
         aufg_pkg::CSR_DEST_PORT:    cfg_shadow.dest_port    = value[15:0];
         aufg_pkg::CSR_IP_IDENT:     cfg_shadow.ip_ident     = value[15:0];
         aufg_pkg::CSR_TIME_TO_LIVE: cfg_shadow.time_to_live = value[7:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   always @(posedge clock) begin
      aufg_pkg::aufg_rsp_type exp_byte;
      if (!reset && rsp_strobe) begin
         if (frame_q.size() == 0) begin
            $display("ERROR %0t: unexpected byte, expected none, got %02h last %0b",
                     $time, rsp_data.frame_byte, rsp_data.last_byte);
            fail_count++;
         end else begin
            exp_byte = frame_q.pop_front();
            bytes_checked++;
            if (rsp_data.frame_byte !== exp_byte.frame_byte) begin
               $display("ERROR %0t: frame_byte expected %02h, got %02h",
                        $time, exp_byte.frame_byte, rsp_data.frame_byte);
               fail_count++;
            end
            if (rsp_data.last_byte !== exp_byte.last_byte) begin
               $display("ERROR %0t: last_byte expected %0b, got %0b",
                        $time, exp_byte.last_byte, rsp_data.last_byte);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("ERROR %0t: timeout with %0d bytes outstanding", $time, frame_q.size());
      $display("arp_udp_frame_generator: mismatch");
      $finish;
   end

   initial begin
      aufg_pkg::aufg_req_type req;
      logic [CSR_W-1:0]       value;
      logic [IDX_W-1:0]       idx;
      int                     r;
      int                     phase;
      int                     n;
      cfg_shadow = '{source_mac: 48'h0, source_ip: 32'h7f00_0001, udp_dest_mac: 48'h0,
                     source_port: 16'd43966, dest_port: 16'd8080, ip_ident: 16'h8397,
                     time_to_live: 8'h40};
      idling = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIR_ROWS; n++) begin
         if (DIR_TABLE[n].kind == ROW_CFG) begin
            wait_idle();
            csr_write(DIR_TABLE[n].idx, DIR_TABLE[n].wdata);
         end else begin
            send_req(DIR_TABLE[n].req, DIR_TABLE[n].has_csum, DIR_TABLE[n].csum);
         end
      end

      for (phase = 0; phase < 8; phase++) begin
         wait_idle();
         for (idx = aufg_pkg::CSR_SOURCE_MAC; idx <= aufg_pkg::CSR_TIME_TO_LIVE; idx++) begin
            r = $urandom_range(0, 9);
            if (phase == 1 || (phase > 2 && r == 0)) begin
               value = '0;
            end else if (phase == 2 || (phase > 2 && r == 1)) begin
               value = '1;
            end else begin
               value = CSR_W'({$urandom(), $urandom()});
            end
            csr_write(idx, value);
         end
         csr_write(CSR_UNUSED, CSR_W'({$urandom(), $urandom()}));
         idling = (phase % 3 != 0);
         for (n = 0; n < 50; n++) begin
            r = $urandom_range(0, 19);
            req.req_type  = 1'($urandom_range(0, 1));
            req.target_ip = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : $urandom();
            send_req(req, 1'b0, 16'h0);
         end
      end

      wait_idle();
      repeat (100) @(posedge clock);
      $display("covered %0d arp and %0d udp frames, %0d bytes checked, %0d register writes",
               arp_frames, udp_frames, bytes_checked, csr_writes);
      $display("settings included all-zero, all-one, over-wide and unknown-index writes");
      if (fail_count == 0 && frame_q.size() == 0) begin
         $display("arp_udp_frame_generator: match");
      end else begin
         $display("arp_udp_frame_generator: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/aufg_pkg.sv
rtl/aufg_cell.sv
rtl/aufg_image.sv
rtl/aufg_csum.sv
rtl/arp_udp_frame_generator.sv
rtl/aufg_checker.sv
sim/tb_arp_udp_frame_generator.sv
